/* src/kclp_pkg.sv */
package kclp_pkg;

    localparam int MaxLineChars = 128;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNKNOWN  = 3'd1;
    localparam logic [2:0] ST_ARGUMENT = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;

    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_STATUS    = 4'd1;
    localparam logic [3:0] CMD_AI_INFO   = 4'd2;
    localparam logic [3:0] CMD_AI_START  = 4'd3;
    localparam logic [3:0] CMD_AI_STOP   = 4'd4;
    localparam logic [3:0] CMD_THRESHOLD = 4'd5;
    localparam logic [3:0] CMD_DS_START  = 4'd6;
    localparam logic [3:0] CMD_DS_STOP   = 4'd7;
    localparam logic [3:0] CMD_STATS_RST = 4'd8;
    localparam logic [3:0] CMD_HELP      = 4'd9;

    localparam logic [1:0] LAB_NONE      = 2'd0;
    localparam logic [1:0] LAB_STABLE    = 2'd1;
    localparam logic [1:0] LAB_VIBRATION = 2'd2;
    localparam logic [1:0] LAB_IMPACT    = 2'd3;

    localparam int KwCount = 13;
    localparam int KW_STATUS    = 0;
    localparam int KW_HELP      = 1;
    localparam int KW_AI        = 2;
    localparam int KW_INFO      = 3;
    localparam int KW_START     = 4;
    localparam int KW_STOP      = 5;
    localparam int KW_THRESHOLD = 6;
    localparam int KW_DATASET   = 7;
    localparam int KW_STABLE    = 8;
    localparam int KW_VIBRATION = 9;
    localparam int KW_IMPACT    = 10;
    localparam int KW_STATS     = 11;
    localparam int KW_RESET     = 12;

    typedef enum logic [6:0] {
        GP_FIRST     = 7'b0000001,
        GP_AI_SUB    = 7'b0000010,
        GP_THR_ARG   = 7'b0000100,
        GP_DS_SUB    = 7'b0001000,
        GP_DS_LABEL  = 7'b0010000,
        GP_STATS_SUB = 7'b0100000,
        GP_DONE      = 7'b1000000
    } grammar_t;

    typedef enum logic [5:0] {
        NP_INT        = 6'b000001,
        NP_DOT        = 6'b000010,
        NP_FIRST_FRAC = 6'b000100,
        NP_FRAC       = 6'b001000,
        NP_BAD        = 6'b010000,
        NP_RANGE      = 6'b100000
    } number_t;

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            KW_STATUS:    kw_len = 4'd6;
            KW_HELP:      kw_len = 4'd4;
            KW_AI:        kw_len = 4'd2;
            KW_INFO:      kw_len = 4'd4;
            KW_START:     kw_len = 4'd5;
            KW_STOP:      kw_len = 4'd4;
            KW_THRESHOLD: kw_len = 4'd9;
            KW_DATASET:   kw_len = 4'd7;
            KW_STABLE:    kw_len = 4'd6;
            KW_VIBRATION: kw_len = 4'd9;
            KW_IMPACT:    kw_len = 4'd6;
            KW_STATS:     kw_len = 4'd5;
            default:      kw_len = 4'd5;
        endcase
    endfunction

    // character of keyword k at position p; 0 past the end never matches a real test
    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [71:0] s;
        s = '0;
        case (k)
            KW_STATUS:    s = {"STATUS", 24'h0};
            KW_HELP:      s = {"HELP", 40'h0};
            KW_AI:        s = {"AI", 56'h0};
            KW_INFO:      s = {"INFO", 40'h0};
            KW_START:     s = {"START", 32'h0};
            KW_STOP:      s = {"STOP", 40'h0};
            KW_THRESHOLD: s = "THRESHOLD";
            KW_DATASET:   s = {"DATASET", 16'h0};
            KW_STABLE:    s = {"STABLE", 24'h0};
            KW_VIBRATION: s = "VIBRATION";
            KW_IMPACT:    s = {"IMPACT", 24'h0};
            KW_STATS:     s = {"STATS", 32'h0};
            default:      s = {"RESET", 32'h0};
        endcase
        if (p < 4'd9)
            kw_char = s[71 - 8 * int'(p) -: 8];
        else
            kw_char = 8'h00;
    endfunction

endpackage

/* src/kclp_kw_match.sv */
module kclp_kw_match (
    input  logic [7:0]                   ch,
    input  logic [3:0]                   pos,
    input  logic [kclp_pkg::KwCount-1:0] mask_in,
    output logic [kclp_pkg::KwCount-1:0] mask_out
);

    always_comb
    begin
        for (int k = 0; k < kclp_pkg::KwCount; k++)
        begin
            mask_out[k] = mask_in[k] && (pos < kclp_pkg::kw_len(k))
                          && (kclp_pkg::kw_char(k, pos) == ch);
        end
    end

endmodule

/* src/keyword_command_line_parser.sv */
// Keyword command line parser.
// Input channel: char_byte / line_end with in_valid / in_ready; one byte per
// transfer, line_end marks the last byte of a line. Output channel:
// parse_status, command_code, label_code, threshold_thousandths with
// out_valid / out_ready; exactly one result per line, issued for the transfer
// that carries line_end.
// Throughput: one byte per cycle while in_ready is high. All token matching
// and the numeric update sit between the input state registers and the
// result register, which shows the result in the cycle after the last byte.
// A result waits in the output register; a new byte is still taken while it
// waits, unless that byte ends another line, which is held until the
// pending result is taken (or taken in the same cycle).
// Reset clears all parse state and empties the output register; after each
// line the parser returns to that reset state.
// Lines longer than MAX_LINE_CHARS report "too long".
module keyword_command_line_parser #(
    parameter int MAX_LINE_CHARS = kclp_pkg::MaxLineChars
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] parse_status,
    output logic [3:0] command_code,
    output logic [1:0] label_code,
    output logic [9:0] threshold_thousandths
);

    localparam int KC = kclp_pkg::KwCount;

    logic [7:0]           char_count_reg, char_count_next;
    logic                 has_token_reg, has_token_next;
    logic [3:0]           token_position_reg, token_position_next;
    logic                 inside_token_reg, inside_token_next;
    logic [KC-1:0]        mask_reg, mask_next;
    kclp_pkg::grammar_t   phase_reg, phase_next;
    logic [2:0]           status_reg, status_next;
    logic [3:0]           cmd_reg, cmd_next;
    logic [1:0]           label_reg, label_next;
    kclp_pkg::number_t    np_reg, np_next;
    logic                 int_digit_reg, int_digit_next;
    logic [9:0]           frac_reg, frac_next;
    logic [1:0]           frac_cnt_reg, frac_cnt_next;

    logic                 out_valid_reg;
    logic [2:0]           o_status_reg;
    logic [3:0]           o_cmd_reg;
    logic [1:0]           o_label_reg;
    logic [9:0]           o_thr_reg;

    logic                 accept, is_space;
    logic [KC-1:0]        match_in, match_out;
    logic [3:0]           pos_use;

    assign in_ready  = !out_valid_reg || out_ready || !line_end;
    assign accept    = in_valid && in_ready;
    assign is_space  = (char_byte == 8'h20) || (char_byte == 8'h09);
    assign pos_use   = inside_token_reg ? token_position_reg : 4'd0;
    assign match_in  = inside_token_reg ? mask_reg : {KC{1'b1}};

    kclp_kw_match u_match (
        .ch       (char_byte),
        .pos      (pos_use),
        .mask_in  (match_in),
        .mask_out (match_out)
    );

    // keyword hit for the token closing on this byte
    function automatic logic hit(input logic [KC-1:0] m, input logic [3:0] p, input int k);
        hit = m[k] && (p == kclp_pkg::kw_len(k));
    endfunction

    logic [3:0] fd;
    logic [9:0] frac_fin;
    logic [9:0] thr_val;
    logic [2:0] status_final;

    always_comb
    begin
        logic [KC-1:0] m;
        logic [3:0]    p;
        logic          end_tok;
        logic          dg;
        logic [2:0]    st;

        char_count_next     = (char_count_reg == 8'd255) ? char_count_reg : char_count_reg + 8'd1;
        has_token_next      = has_token_reg;
        token_position_next = token_position_reg;
        inside_token_next   = inside_token_reg;
        mask_next           = mask_reg;
        phase_next          = phase_reg;
        status_next         = status_reg;
        cmd_next            = cmd_reg;
        label_next          = label_reg;
        np_next             = np_reg;
        int_digit_next      = int_digit_reg;
        frac_next           = frac_reg;
        frac_cnt_next       = frac_cnt_reg;
        fd                  = char_byte[3:0];
        dg                  = (char_byte >= 8'h30) && (char_byte <= 8'h39);
        st                  = kclp_pkg::ST_OK;
        end_tok             = 1'b0;

        if (!is_space)
        begin
            if (!inside_token_reg)
            begin
                np_next        = kclp_pkg::NP_INT;
                int_digit_next = 1'b0;
                frac_next      = '0;
                frac_cnt_next  = '0;
                has_token_next = 1'b1;
            end
            inside_token_next   = 1'b1;
            mask_next           = match_out;
            token_position_next = (pos_use == 4'd15) ? pos_use : pos_use + 4'd1;
            unique case (inside_token_reg ? np_reg : kclp_pkg::NP_INT)
                kclp_pkg::NP_INT:
                    if (char_byte == 8'h30 || char_byte == 8'h31)
                    begin
                        int_digit_next = char_byte[0];
                        np_next        = kclp_pkg::NP_DOT;
                    end
                    else
                        np_next = kclp_pkg::NP_BAD;
                kclp_pkg::NP_DOT:
                    np_next = (char_byte == 8'h2E) ? kclp_pkg::NP_FIRST_FRAC : kclp_pkg::NP_BAD;
                kclp_pkg::NP_FIRST_FRAC, kclp_pkg::NP_FRAC:
                    if (!dg)
                        np_next = kclp_pkg::NP_BAD;
                    else if (frac_cnt_reg == 2'd3)
                        np_next = kclp_pkg::NP_RANGE;
                    else
                    begin
                        frac_next     = 10'(frac_reg * 10'd10 + {6'd0, fd});
                        frac_cnt_next = frac_cnt_reg + 2'd1;
                        np_next       = kclp_pkg::NP_FRAC;
                    end
                default: ;
            endcase
        end

        // token closes on a separator, or at line end if still open
        end_tok = accept && (is_space ? inside_token_reg : line_end);
        m       = is_space ? mask_reg : mask_next;
        p       = is_space ? token_position_reg : token_position_next;

        unique case (frac_cnt_next)
            2'd0:    frac_fin = 10'd0;
            2'd1:    frac_fin = 10'(frac_next * 10'd100);
            2'd2:    frac_fin = 10'(frac_next * 10'd10);
            default: frac_fin = frac_next;
        endcase

        if (end_tok)
        begin
            inside_token_next = 1'b0;
            if (status_reg == kclp_pkg::ST_OK)
            begin
                unique case (phase_reg)
                    kclp_pkg::GP_FIRST:
                        if (hit(m, p, kclp_pkg::KW_STATUS))
                        begin
                            cmd_next = kclp_pkg::CMD_STATUS; phase_next = kclp_pkg::GP_DONE;
                        end
                        else if (hit(m, p, kclp_pkg::KW_AI))
                            phase_next = kclp_pkg::GP_AI_SUB;
                        else if (hit(m, p, kclp_pkg::KW_DATASET))
                            phase_next = kclp_pkg::GP_DS_SUB;
                        else if (hit(m, p, kclp_pkg::KW_STATS))
                            phase_next = kclp_pkg::GP_STATS_SUB;
                        else if (hit(m, p, kclp_pkg::KW_HELP))
                        begin
                            cmd_next = kclp_pkg::CMD_HELP; phase_next = kclp_pkg::GP_DONE;
                        end
                        else
                            status_next = kclp_pkg::ST_UNKNOWN;
                    kclp_pkg::GP_AI_SUB:
                        if (hit(m, p, kclp_pkg::KW_INFO))
                        begin
                            cmd_next = kclp_pkg::CMD_AI_INFO; phase_next = kclp_pkg::GP_DONE;
                        end
                        else if (hit(m, p, kclp_pkg::KW_START))
                        begin
                            cmd_next = kclp_pkg::CMD_AI_START; phase_next = kclp_pkg::GP_DONE;
                        end
                        else if (hit(m, p, kclp_pkg::KW_STOP))
                        begin
                            cmd_next = kclp_pkg::CMD_AI_STOP; phase_next = kclp_pkg::GP_DONE;
                        end
                        else if (hit(m, p, kclp_pkg::KW_THRESHOLD))
                            phase_next = kclp_pkg::GP_THR_ARG;
                        else
                            status_next = kclp_pkg::ST_UNKNOWN;
                    kclp_pkg::GP_THR_ARG:
                        if (np_next == kclp_pkg::NP_BAD || np_next == kclp_pkg::NP_FIRST_FRAC
                            || np_next == kclp_pkg::NP_INT)
                            status_next = kclp_pkg::ST_ARGUMENT;
                        else if (np_next == kclp_pkg::NP_RANGE)
                            status_next = kclp_pkg::ST_RANGE;
                        else if (int_digit_next && frac_fin != 10'd0)
                            status_next = kclp_pkg::ST_RANGE;
                        else
                        begin
                            frac_next     = frac_fin;
                            frac_cnt_next = 2'd3;
                            cmd_next      = kclp_pkg::CMD_THRESHOLD;
                            phase_next    = kclp_pkg::GP_DONE;
                        end
                    kclp_pkg::GP_DS_SUB:
                        if (hit(m, p, kclp_pkg::KW_STOP))
                        begin
                            cmd_next = kclp_pkg::CMD_DS_STOP; phase_next = kclp_pkg::GP_DONE;
                        end
                        else if (hit(m, p, kclp_pkg::KW_START))
                            phase_next = kclp_pkg::GP_DS_LABEL;
                        else
                            status_next = kclp_pkg::ST_UNKNOWN;
                    kclp_pkg::GP_DS_LABEL:
                    begin
                        if (hit(m, p, kclp_pkg::KW_STABLE))
                            label_next = kclp_pkg::LAB_STABLE;
                        else if (hit(m, p, kclp_pkg::KW_VIBRATION))
                            label_next = kclp_pkg::LAB_VIBRATION;
                        else if (hit(m, p, kclp_pkg::KW_IMPACT))
                            label_next = kclp_pkg::LAB_IMPACT;
                        if (hit(m, p, kclp_pkg::KW_STABLE) || hit(m, p, kclp_pkg::KW_VIBRATION)
                            || hit(m, p, kclp_pkg::KW_IMPACT))
                        begin
                            cmd_next = kclp_pkg::CMD_DS_START; phase_next = kclp_pkg::GP_DONE;
                        end
                        else
                            status_next = kclp_pkg::ST_ARGUMENT;
                    end
                    kclp_pkg::GP_STATS_SUB:
                        if (hit(m, p, kclp_pkg::KW_RESET))
                        begin
                            cmd_next = kclp_pkg::CMD_STATS_RST; phase_next = kclp_pkg::GP_DONE;
                        end
                        else
                            status_next = kclp_pkg::ST_UNKNOWN;
                    default:
                        status_next = kclp_pkg::ST_ARGUMENT;
                endcase
            end
        end

        if (int'(char_count_next) > MAX_LINE_CHARS)
            st = kclp_pkg::ST_TOO_LONG;
        else if (status_next != kclp_pkg::ST_OK)
            st = status_next;
        else if (!has_token_next)
            st = kclp_pkg::ST_EMPTY;
        else if (phase_next == kclp_pkg::GP_DONE)
            st = kclp_pkg::ST_OK;
        else if (phase_next == kclp_pkg::GP_THR_ARG || phase_next == kclp_pkg::GP_DS_LABEL)
            st = kclp_pkg::ST_ARGUMENT;
        else
            st = kclp_pkg::ST_UNKNOWN;
        status_final = st;
        thr_val = int_digit_next ? 10'd1000 : frac_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg     <= '0;
            has_token_reg      <= 1'b0;
            token_position_reg <= '0;
            inside_token_reg   <= 1'b0;
            mask_reg           <= {KC{1'b1}};
            phase_reg          <= kclp_pkg::GP_FIRST;
            status_reg         <= kclp_pkg::ST_OK;
            cmd_reg            <= kclp_pkg::CMD_NONE;
            label_reg          <= kclp_pkg::LAB_NONE;
            np_reg             <= kclp_pkg::NP_INT;
            int_digit_reg      <= 1'b0;
            frac_reg           <= '0;
            frac_cnt_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept && line_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                if (line_end)
                begin
                    char_count_reg     <= '0;
                    has_token_reg      <= 1'b0;
                    token_position_reg <= '0;
                    inside_token_reg   <= 1'b0;
                    mask_reg           <= {KC{1'b1}};
                    phase_reg          <= kclp_pkg::GP_FIRST;
                    status_reg         <= kclp_pkg::ST_OK;
                    cmd_reg            <= kclp_pkg::CMD_NONE;
                    label_reg          <= kclp_pkg::LAB_NONE;
                    np_reg             <= kclp_pkg::NP_INT;
                    int_digit_reg      <= 1'b0;
                    frac_reg           <= '0;
                    frac_cnt_reg       <= '0;
                end
                else
                begin
                    char_count_reg     <= char_count_next;
                    has_token_reg      <= has_token_next;
                    token_position_reg <= token_position_next;
                    inside_token_reg   <= inside_token_next;
                    mask_reg           <= mask_next;
                    phase_reg          <= phase_next;
                    status_reg         <= status_next;
                    cmd_reg            <= cmd_next;
                    label_reg          <= label_next;
                    np_reg             <= np_next;
                    int_digit_reg      <= int_digit_next;
                    frac_reg           <= frac_next;
                    frac_cnt_reg       <= frac_cnt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && line_end)
        begin
            o_status_reg <= status_final;
            if (status_final == kclp_pkg::ST_OK)
            begin
                o_cmd_reg   <= cmd_next;
                o_label_reg <= (cmd_next == kclp_pkg::CMD_DS_START) ? label_next
                                                                    : kclp_pkg::LAB_NONE;
                o_thr_reg   <= (cmd_next == kclp_pkg::CMD_THRESHOLD) ? thr_val : 10'd0;
            end
            else
            begin
                o_cmd_reg   <= kclp_pkg::CMD_NONE;
                o_label_reg <= kclp_pkg::LAB_NONE;
                o_thr_reg   <= 10'd0;
            end
        end
    end

    assign out_valid             = out_valid_reg;
    assign parse_status          = o_status_reg;
    assign command_code          = o_cmd_reg;
    assign label_code            = o_label_reg;
    assign threshold_thousandths = o_thr_reg;

endmodule
